// ===== design/i2cms_pkg.sv =====
// Types, command codes and microcode format for the I2C master bit sequencer.
`timescale 1ns / 1ps

package i2cms_pkg;

   // Command codes
   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_STOP  = 3'd1;
   localparam logic [2:0] CMD_SEND  = 3'd2;
   localparam logic [2:0] CMD_RECV  = 3'd3;
   localparam logic [2:0] CMD_SACK  = 3'd4;
   localparam logic [2:0] CMD_RACK  = 3'd5;

   localparam int UC_ADDR_W = 5;
   localparam int CNT_W     = 3;

   // Microcode entry points
   localparam logic [UC_ADDR_W-1:0] UC_START = 5'd0;
   localparam logic [UC_ADDR_W-1:0] UC_STOP  = 5'd4;
   localparam logic [UC_ADDR_W-1:0] UC_SEND  = 5'd7;
   localparam logic [UC_ADDR_W-1:0] UC_RECV  = 5'd10;
   localparam logic [UC_ADDR_W-1:0] UC_SACK  = 5'd13;
   localparam logic [UC_ADDR_W-1:0] UC_RACK  = 5'd16;
   localparam logic [UC_ADDR_W-1:0] UC_LAST  = 5'd18;

   localparam logic [CNT_W-1:0] CNT_LAST = 3'd7;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] tx_byte;
      logic       ack_to_send;
      logic [7:0] line_bits;
      logic       line_ack;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_drive;
      logic [7:0] rx_byte;
      logic       ack_received;
      logic       last;
   } rsp_type;

   typedef enum logic {PIN_SDA, PIN_SCL} pin_type;
   typedef enum logic [1:0] {SRC_ZERO, SRC_ONE, SRC_TX, SRC_ACK} src_type;
   typedef enum logic [1:0] {SEQ_NEXT, SEQ_END, SEQ_LOOP} seq_type;
   typedef enum logic [1:0] {REP_NONE, REP_RX, REP_ACK} rep_type;

   typedef struct packed {
      pin_type                pin;
      src_type                src;
      seq_type                seq;
      logic                   sample;
      rep_type                rep;
      logic [UC_ADDR_W-1:0]   target;
   } ucode_type;

   // Sequencer to datapath control
   typedef struct packed {
      logic             load;
      logic             step;
      logic             fin;
      logic [CNT_W-1:0] cnt;
      ucode_type        cw;
   } dp_ctl_type;

   typedef struct packed {
      logic                 valid;
      logic [UC_ADDR_W-1:0] addr;
   } entry_type;

   function automatic entry_type cmd_entry(input logic [2:0] cmd);
      entry_type e;
      e.valid = 1'b1;
      case (cmd)
         CMD_START: e.addr = UC_START;
         CMD_STOP:  e.addr = UC_STOP;
         CMD_SEND:  e.addr = UC_SEND;
         CMD_RECV:  e.addr = UC_RECV;
         CMD_SACK:  e.addr = UC_SACK;
         CMD_RACK:  e.addr = UC_RACK;
         default: begin
            e.valid = 1'b0;
            e.addr  = UC_START;
         end
      endcase
      return e;
   endfunction

endpackage

// ===== design/i2cms_ucode_rom.sv =====
// Microcode table: one control word per sequencer step.
`timescale 1ns / 1ps

module i2cms_ucode_rom (
   input  logic [i2cms_pkg::UC_ADDR_W-1:0] pc,
   output i2cms_pkg::ucode_type            cw
);
   import i2cms_pkg::*;

   function automatic ucode_type uw(input pin_type p, input src_type s, input seq_type q,
                                    input logic smp, input rep_type r,
                                    input logic [UC_ADDR_W-1:0] t);
      ucode_type w;
      w.pin    = p;
      w.src    = s;
      w.seq    = q;
      w.sample = smp;
      w.rep    = r;
      w.target = t;
      return w;
   endfunction

   always_comb begin
      case (pc)
         // start
         UC_START:        cw = uw(PIN_SDA, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_START);
         UC_START + 5'd1: cw = uw(PIN_SCL, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_START);
         UC_START + 5'd2: cw = uw(PIN_SDA, SRC_ZERO, SEQ_NEXT, 1'b0, REP_NONE, UC_START);
         UC_START + 5'd3: cw = uw(PIN_SCL, SRC_ZERO, SEQ_END,  1'b0, REP_NONE, UC_START);
         // stop
         UC_STOP:         cw = uw(PIN_SDA, SRC_ZERO, SEQ_NEXT, 1'b0, REP_NONE, UC_STOP);
         UC_STOP + 5'd1:  cw = uw(PIN_SCL, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_STOP);
         UC_STOP + 5'd2:  cw = uw(PIN_SDA, SRC_ONE,  SEQ_END,  1'b0, REP_NONE, UC_STOP);
         // send byte, eight passes
         UC_SEND:         cw = uw(PIN_SDA, SRC_TX,   SEQ_NEXT, 1'b0, REP_NONE, UC_SEND);
         UC_SEND + 5'd1:  cw = uw(PIN_SCL, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_SEND);
         UC_SEND + 5'd2:  cw = uw(PIN_SCL, SRC_ZERO, SEQ_LOOP, 1'b0, REP_NONE, UC_SEND);
         // receive byte: release, then eight sample passes
         UC_RECV:         cw = uw(PIN_SDA, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_RECV);
         UC_RECV + 5'd1:  cw = uw(PIN_SCL, SRC_ONE,  SEQ_NEXT, 1'b1, REP_NONE, UC_RECV);
         UC_RECV + 5'd2:  cw = uw(PIN_SCL, SRC_ZERO, SEQ_LOOP, 1'b0, REP_RX,
                                  UC_RECV + 5'd1);
         // send ack
         UC_SACK:         cw = uw(PIN_SDA, SRC_ACK,  SEQ_NEXT, 1'b0, REP_NONE, UC_SACK);
         UC_SACK + 5'd1:  cw = uw(PIN_SCL, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_SACK);
         UC_SACK + 5'd2:  cw = uw(PIN_SCL, SRC_ZERO, SEQ_END,  1'b0, REP_NONE, UC_SACK);
         // receive ack
         UC_RACK:         cw = uw(PIN_SDA, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_RACK);
         UC_RACK + 5'd1:  cw = uw(PIN_SCL, SRC_ONE,  SEQ_NEXT, 1'b0, REP_NONE, UC_RACK);
         UC_LAST:         cw = uw(PIN_SCL, SRC_ZERO, SEQ_END,  1'b0, REP_ACK,  UC_RACK);
         default:         cw = uw(PIN_SCL, SRC_ZERO, SEQ_END,  1'b0, REP_NONE, UC_START);
      endcase
   end

endmodule

// ===== design/i2cms_datapath.sv =====
// Pin level registers, command hold register and receive shifter.
`timescale 1ns / 1ps

module i2cms_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  i2cms_pkg::req_type    req_payload,
   input  i2cms_pkg::dp_ctl_type ctl,
   output i2cms_pkg::rsp_type    result
);
   import i2cms_pkg::*;

   req_type    cmd_ff, cmd_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic [7:0] rx_ff, rx_in;
   logic       value;
   logic [2:0] bit_idx;

   // passes run bit 7 first
   assign bit_idx = ~ctl.cnt;

   always_comb begin
      case (ctl.cw.src)
         SRC_ZERO: value = 1'b0;
         SRC_ONE:  value = 1'b1;
         SRC_TX:   value = cmd_ff.tx_byte[bit_idx];
         SRC_ACK:  value = cmd_ff.ack_to_send;
         default:  value = 1'b1;
      endcase
   end

   always_comb begin
      cmd_in = ctl.load ? req_payload : cmd_ff;
      scl_in = scl_ff;
      sda_in = sda_ff;
      rx_in  = rx_ff;
      if (ctl.load) begin
         rx_in = '0;
      end else if (ctl.step) begin
         if (ctl.cw.pin == PIN_SCL) begin
            scl_in = value;
         end else begin
            sda_in = value;
         end
         if (ctl.cw.sample) begin
            rx_in = {rx_ff[6:0], cmd_ff.line_bits[bit_idx]};
         end
      end
   end

   always_comb begin
      result.scl          = scl_in;
      result.sda_drive    = sda_in;
      result.rx_byte      = (ctl.fin && ctl.cw.rep == REP_RX) ? rx_ff : 8'd0;
      result.ack_received = ctl.fin && ctl.cw.rep == REP_ACK && cmd_ff.line_ack;
      result.last         = ctl.fin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_ff <= 1'b1;
         sda_ff <= 1'b1;
      end else begin
         scl_ff <= scl_in;
         sda_ff <= sda_in;
      end
      cmd_ff <= cmd_in;
      rx_ff  <= rx_in;
   end

endmodule

// ===== design/i2c_master_bit_sequencer.sv =====
// Top level: microcoded I2C master pin-write sequencer with registered result channel.
// A command is taken only while the sequencer is idle; then one pin write per cycle follows,
// unless the output register holds a stalled result, paced by the microcode step counter
// (3, 4, 17 or 24 writes per command). No new command is taken until the last one is done;
// unused command codes are taken and produce no transaction.
// Reset: both pins released high, sequencer idle, no result pending.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  i2cms_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output i2cms_pkg::rsp_type rsp_payload
);
   import i2cms_pkg::*;

   // Sequencer state: busy flag, microcode address, bit pass counter
   logic                 busy_ff, busy_in;
   logic [UC_ADDR_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   ucode_type            cw;
   dp_ctl_type           ctl;
   entry_type            entry;
   rsp_type              result;
   logic                 accept;
   logic                 step;
   logic                 loop_done;

   i2cms_ucode_rom u_rom (
      .pc (pc_ff),
      .cw (cw)
   );

   i2cms_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ctl         (ctl),
      .result      (result)
   );

   // One command at a time; a finished result may still sit in the output register.
   assign req_stall = busy_ff;
   assign accept    = req_valid && !busy_ff;
   assign entry     = cmd_entry(req_payload.command);

   // A step runs only when the output register can take its pin write.
   assign step      = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign loop_done = (cnt_ff == CNT_LAST);

   always_comb begin
      ctl.load = accept;
      ctl.step = step;
      ctl.cnt  = cnt_ff;
      ctl.cw   = cw;
      case (cw.seq)
         SEQ_END:  ctl.fin = 1'b1;
         SEQ_LOOP: ctl.fin = loop_done;
         default:  ctl.fin = 1'b0;
      endcase
   end

   // Next microcode address and pass counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      if (accept) begin
         busy_in = entry.valid;
         pc_in   = entry.addr;
         cnt_in  = '0;
      end else if (step) begin
         case (cw.seq)
            SEQ_NEXT: pc_in = pc_ff + 5'd1;
            SEQ_END:  busy_in = 1'b0;
            SEQ_LOOP: begin
               if (loop_done) begin
                  busy_in = 1'b0;
                  cnt_in  = '0;
               end else begin
                  pc_in  = cw.target;
                  cnt_in = cnt_ff + 3'd1;
               end
            end
            default:  busy_in = 1'b0;
         endcase
      end
   end

   // Output register loads each pin write, drains on the downstream side
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= UC_START;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // Microcode address stays inside the table while a command runs
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= UC_LAST)
      else $error("microcode address out of range");

   // A known command always starts the sequencer
   a_start: assert property (@(posedge clock) disable iff (reset)
      (accept && entry.valid) |=> busy_ff)
      else $error("valid command did not start sequencer");

   // Pass counter only runs inside the send and receive byte loops
   a_cnt_loop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 3'd0) |-> (busy_ff && pc_ff >= UC_SEND && pc_ff < UC_SACK))
      else $error("pass counter active outside a byte loop");

   // Sampled data only appears on the final write of a command
   a_rx_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.rx_byte != 8'd0 || rsp_ff.ack_received)) |-> rsp_ff.last)
      else $error("sampled data on a non-final pin write");
`endif

endmodule
